// ===== rtl/rdsc_pkg.sv =====
// Shared types, constants and a helper function of the radix digit string converter.
package rdsc_pkg;

    localparam int VALUE_PORT_W = 64;
    localparam int CHAR_W       = 7;
    localparam int RADIX_W      = 5;
    localparam int DIGIT_W      = 8;
    localparam int REM_W        = 4;
    localparam int DIV_BITS     = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO        = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_LETTER_BASE = 7'd87;
    localparam logic [REM_W-1:0]  FIRST_LETTER      = 4'd10;

    typedef struct packed {
        logic load;
        logic div;
        logic store;
        logic rd;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic q_zero;
        logic n_last;
        logic idx_zero;
        logic out_free;
    } ctrl_sts_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < FIRST_LETTER)
        begin
            return d_ext + ASCII_ZERO;
        end
        return d_ext + ASCII_LETTER_BASE;
    endfunction

endpackage

// ===== rtl/rdsc_if.sv =====
// Handshake channel interfaces for number items, character items and the radix register.
interface rdsc_num_if;
    logic                             valid;
    logic                             ready;
    logic [rdsc_pkg::VALUE_PORT_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface rdsc_txt_if;
    logic                        valid;
    logic                        ready;
    logic [rdsc_pkg::CHAR_W-1:0] digit_char;
    logic                        last_char;

    modport source (output valid, output digit_char, output last_char, input ready);
    modport sink (input valid, input digit_char, input last_char, output ready);
endinterface

interface rdsc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rdsc_pkg::RADIX_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rdsc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module rdsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rdsc_ctrl.sv =====
// Controller state machine sequencing division, digit storage and character output.
module rdsc_ctrl #(
    parameter int DIV_CYC = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_ready,
    input  rdsc_pkg::ctrl_sts_t sts,
    output rdsc_pkg::ctrl_cmd_t cmd
);
    import rdsc_pkg::*;

    localparam int CNT_W = $clog2(DIV_CYC + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_STORE = 5'b00100,
        S_RD    = 5'b01000,
        S_LOAD  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        num_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                num_ready = 1'b1;
                if (num_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div   = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(DIV_CYC - 1))
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                step_next = '0;
                if (sts.q_zero || sts.n_last)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = sts.idx_zero ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== rtl/rdsc_dp.sv =====
// Datapath: radix register, digit-serial divider, digit store and output register.
module rdsc_dp #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rdsc_cfg_if.sink                            cfg,
    input  logic [rdsc_pkg::VALUE_PORT_W-1:0]   num_value,
    rdsc_txt_if.source                          txt,
    input  rdsc_pkg::ctrl_cmd_t                 cmd,
    output rdsc_pkg::ctrl_sts_t                 sts
);
    import rdsc_pkg::*;

    localparam int DIV_CYC = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int WW      = DIV_CYC * DIV_BITS;
    localparam int N_W     = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W   = $clog2(MAX_DIGITS);

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] eff_radix;
    logic [WW-1:0]      w_reg, w_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    logic [REM_W-1:0]   div_rem;
    logic [DIV_BITS-1:0] div_qbits;
    logic [DIGIT_W-1:0] rd_digit;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg.valid)
        begin
            radix_reg <= cfg.data;
        end
    end

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            eff_radix = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            eff_radix = RADIX_MAX;
        end
        else
        begin
            eff_radix = radix_reg;
        end
    end

    // Long division of the top DIV_BITS dividend bits per cycle; the quotient bits
    // shift in at the bottom so that once every dividend bit has been shifted through, w_reg holds the quotient.
    always_comb
    begin
        logic [REM_W-1:0]   rem_v;
        logic [RADIX_W-1:0] t_v;
        rem_v     = rem_reg;
        div_qbits = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t_v = {rem_v, w_reg[WW-1-i]};
            if (t_v >= eff_radix)
            begin
                t_v                     = t_v - eff_radix;
                div_qbits[DIV_BITS-1-i] = 1'b1;
            end
            rem_v = t_v[REM_W-1:0];
        end
        div_rem = rem_v;
    end

    always_comb
    begin
        w_next   = w_reg;
        rem_next = rem_reg;
        n_next   = n_reg;
        idx_next = idx_reg;
        if (cmd.load)
        begin
            w_next   = WW'(num_value[VALUE_WIDTH-1:0]);
            rem_next = '0;
            n_next   = '0;
        end
        if (cmd.div)
        begin
            w_next   = {w_reg[WW-DIV_BITS-1:0], div_qbits};
            rem_next = div_rem;
        end
        if (cmd.store)
        begin
            rem_next = '0;
            n_next   = n_reg + 1'b1;
            idx_next = n_reg[IDX_W-1:0];
        end
        if (cmd.load_out && idx_reg != '0)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        rem_reg  <= rem_next;
        idx_reg  <= idx_next;
        if (cmd.load_out)
        begin
            char_reg <= digit_to_ascii(rd_digit[REM_W-1:0]);
            last_reg <= (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (txt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    rdsc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_store (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (n_reg[IDX_W-1:0]),
        .wdata (DIGIT_W'(rem_reg)),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (rd_digit)
    );

    assign sts.q_zero   = (w_reg == '0);
    assign sts.n_last   = (n_reg == N_W'(MAX_DIGITS - 1));
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.out_free = !out_valid_reg || txt.ready;

    assign txt.valid      = out_valid_reg;
    assign txt.digit_char = char_reg;
    assign txt.last_char  = last_reg;

endmodule

// ===== rtl/radix_digit_string_converter_top.sv =====
// Digits are formed first by division passes, each followed by a store, then characters go out most significant first.
// The divider retires 8 quotient bits per cycle.
// One number is in work at a time; the next is accepted once the last character is loaded.
// Reset clears the controller, digit count, output valid and sets the radix to ten.
// The digit store is not cleared; every entry is written before it is read.
module radix_digit_string_converter_top #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    rdsc_cfg_if.sink   cfg,
    rdsc_num_if.sink   num,
    rdsc_txt_if.source txt
);
    import rdsc_pkg::*;

    localparam int DIV_CYC = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    rdsc_ctrl #(
        .DIV_CYC (DIV_CYC)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num.valid),
        .num_ready (num.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rdsc_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .num_value (num.value),
        .txt       (txt),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A new number is never taken on the cycle right after one was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        num.valid && num.ready |=> !num.ready)
        else $error("input accepted while a number is in work");

    // The output register is only reloaded when it is empty or being drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("output character overwritten before it was taken");

    // Loading a number always starts a division pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.div)
        else $error("division did not start after load");

endmodule
